// File: sv/rne_pkg.sv
// Package for the Roman numeral encoder: field widths, symbol codes,
// digit patterns and the symbol table for each decimal position.
// No dependencies; every other file imports it.
package rne_pkg;

	localparam int NUM_W      = 20;  // binary input width
	localparam int SYM_W      = 3;   // symbol code width
	localparam int MAX_POS    = 6;   // decimal positions supported
	localparam int POS_W      = 3;   // position index width
	localparam int DIGITS_DEF = 6;   // default number of positions
	localparam int LEN_W      = 3;   // symbols per digit, 0..4
	localparam int K_W        = 2;   // symbol index within a digit

	// Symbol codes
	localparam logic [SYM_W-1:0] SYM_I = 3'd0;
	localparam logic [SYM_W-1:0] SYM_V = 3'd1;
	localparam logic [SYM_W-1:0] SYM_X = 3'd2;
	localparam logic [SYM_W-1:0] SYM_L = 3'd3;
	localparam logic [SYM_W-1:0] SYM_C = 3'd4;
	localparam logic [SYM_W-1:0] SYM_D = 3'd5;
	localparam logic [SYM_W-1:0] SYM_M = 3'd6;

	// Symbol kinds within a position
	typedef enum logic [1:0] {
		KIND_ONE  = 2'd0,
		KIND_FIVE = 2'd1,
		KIND_TEN  = 2'd2
	} kind_t;

	// One emitted symbol: barred flag and code
	typedef struct packed {
		logic             bar;
		logic [SYM_W-1:0] code;
	} sym_t;

	// Converter status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} conv_stat_t;

	// Clamp the position count to the supported range
	function automatic int clamp_digits(input int n);
		int r;
		r = n;
		if (r < 1) r = 1;
		if (r > MAX_POS) r = MAX_POS;
		return r;
	endfunction

	// Largest value that n decimal positions can hold, worked out at elaboration
	function automatic logic [NUM_W-1:0] max_value(input int n);
		int acc;
		acc = 1;
		for (int i = 0; i < n; i++) acc = acc * 10;
		return NUM_W'(acc - 1);
	endfunction

	// Number of symbols that a decimal digit is written with
	function automatic logic [LEN_W-1:0] pat_len(input logic [3:0] d);
		logic [LEN_W-1:0] r;
		case (d)
			4'd1:    r = 3'd1;
			4'd2:    r = 3'd2;
			4'd3:    r = 3'd3;
			4'd4:    r = 3'd2;
			4'd5:    r = 3'd1;
			4'd6:    r = 3'd2;
			4'd7:    r = 3'd3;
			4'd8:    r = 3'd4;
			4'd9:    r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Kind of the k-th symbol of a digit
	function automatic kind_t pat_kind(input logic [3:0] d, input logic [K_W-1:0] k);
		kind_t r;
		r = KIND_ONE;
		case (d)
			4'd4:                   r = (k == 2'd1) ? KIND_FIVE : KIND_ONE;
			4'd5, 4'd6, 4'd7, 4'd8: r = (k == 2'd0) ? KIND_FIVE : KIND_ONE;
			4'd9:                   r = (k == 2'd1) ? KIND_TEN : KIND_ONE;
			default:                r = KIND_ONE;
		endcase
		return r;
	endfunction

	// Symbol for a kind at a position, units first
	function automatic sym_t pos_code(input logic [POS_W-1:0] p, input kind_t kind);
		sym_t one, five, ten, r;
		case (p)
			3'd0: begin
				one = '{1'b0, SYM_I}; five = '{1'b0, SYM_V}; ten = '{1'b0, SYM_X};
			end
			3'd1: begin
				one = '{1'b0, SYM_X}; five = '{1'b0, SYM_L}; ten = '{1'b0, SYM_C};
			end
			3'd2: begin
				one = '{1'b0, SYM_C}; five = '{1'b0, SYM_D}; ten = '{1'b0, SYM_M};
			end
			3'd3: begin
				one = '{1'b0, SYM_M}; five = '{1'b1, SYM_V}; ten = '{1'b1, SYM_X};
			end
			3'd4: begin
				one = '{1'b1, SYM_X}; five = '{1'b1, SYM_L}; ten = '{1'b1, SYM_C};
			end
			3'd5: begin
				one = '{1'b1, SYM_C}; five = '{1'b1, SYM_D}; ten = '{1'b1, SYM_M};
			end
			default: begin
				one = '{1'b0, SYM_I}; five = '{1'b0, SYM_I}; ten = '{1'b0, SYM_I};
			end
		endcase
		case (kind)
			KIND_FIVE: r = five;
			KIND_TEN:  r = ten;
			default:   r = one;
		endcase
		return r;
	endfunction

endpackage

// File: sv/rne_ifs.sv
// Channel interfaces of the Roman numeral encoder: the number word in
// and the symbol word out, each with valid/ready. Depends on rne_pkg.
interface rne_num_if;
	import rne_pkg::*;
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rne_sym_if;
	import rne_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             overline;
	logic             last;

	modport source (output valid, output symbol, output overline, output last, input ready);
	modport sink   (input valid, input symbol, input overline, input last, output ready);
endinterface

// File: sv/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: control sequencer tying the
// bit-serial converter to the symbol sequencer. Depends on rne_pkg,
// rne_ifs, rne_bin2bcd and rne_emit.
//
//   channel  dir  payload                        word
//   num      in   value[19:0]                    one number
//   sym      out  symbol[2:0], overline, last    one symbol
//
// Each accepted number goes through the shift-and-add-3 converter, one input
// bit at a time; then the sequencer is loaded and walks every symbol and every
// zero digit above the lowest nonzero digit, and control returns to idle.
// Zero gives no output. A stalled sym port holds the sequencer; the next
// number is accepted once the sequencer has issued its final symbol. Reset
// clears all control state.
module roman_numeral_encoder #(
	parameter int DIGITS = rne_pkg::DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rne_num_if.sink   num,
	rne_sym_if.source sym
);
	import rne_pkg::*;

	localparam int NPOS = clamp_digits(DIGITS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t          state_q;
	conv_stat_t      conv_stat;
	logic [4*NPOS-1:0] bcd;
	logic            emit_busy;
	logic            start;
	logic            load;

	assign num.ready = (state_q == S_IDLE);
	assign start     = num.valid && num.ready;
	assign load      = (state_q == S_CONV) && conv_stat.done;

	// Sequence one number at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_CONV;
				S_CONV: if (conv_stat.done) state_q <= S_EMIT;
				S_EMIT: if (!emit_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	rne_bin2bcd #(.DIGITS(NPOS)) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (num.value),
		.stat   (conv_stat),
		.bcd    (bcd)
	);

	rne_emit #(.DIGITS(NPOS)) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.bcd    (bcd),
		.busy   (emit_busy),
		.sym    (sym)
	);

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!conv_stat.busy && !emit_busy))
		else $error("idle while a unit is still busy");
`endif

endmodule

// File: sv/rne_bin2bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle, with saturation to the largest value. Depends on rne_pkg.
module rne_bin2bcd #(
	parameter int DIGITS = rne_pkg::DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rne_pkg::NUM_W-1:0]     value,
	output rne_pkg::conv_stat_t           stat,
	output logic [4*DIGITS-1:0]           bcd
);
	import rne_pkg::*;

	localparam int DW = 4 * DIGITS;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [NUM_W-1:0] MAXV = max_value(DIGITS);

	logic [NUM_W-1:0] bin_q;
	logic [DW-1:0]    bcd_q;
	logic [DW-1:0]    adj;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             last_bit;

	// Add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	assign last_bit = (cnt_q == CNT_W'(NUM_W - 1));

	// Load, then shift one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= (value > MAXV) ? MAXV : value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			bcd_q <= {adj[DW-2:0], bin_q[NUM_W-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("converter restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last_bit) |=> (done_q && !busy_q))
		else $error("converter did not finish after the last bit");
`endif

endmodule

// File: sv/rne_emit.sv
// Symbol sequencer: walks BCD digits from the top, one symbol or skipped zero
// digit per unstalled cycle, into a registered output. Depends on rne_pkg.
module rne_emit #(
	parameter int DIGITS = rne_pkg::DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [4*DIGITS-1:0]  bcd,
	output logic                 busy,
	rne_sym_if.source            sym
);
	import rne_pkg::*;

	localparam int DW = 4 * DIGITS;

	logic [DW-1:0]    dig_q;
	logic [POS_W-1:0] pos_q;
	logic [K_W-1:0]   k_q;
	logic             busy_q;
	logic             valid_q;
	logic [SYM_W-1:0] code_q;
	logic             bar_q;
	logic             last_q;

	logic [3:0]       d;
	logic [LEN_W-1:0] len;
	logic [DW-1:0]    rest;
	logic             rest_zero;
	logic             k_last;
	logic             step;
	logic             emit_now;
	logic             digit_end;
	sym_t             cur;

	// Decode the current top digit
	assign d         = dig_q[DW-1 -: 4];
	assign len       = pat_len(d);
	assign rest      = dig_q << 4;
	assign rest_zero = (rest == '0);
	assign k_last    = ((LEN_W'(k_q) + 1'b1) == len);
	assign cur       = pos_code(pos_q, pat_kind(d, k_q));
	assign step      = busy_q && (!valid_q || sym.ready);
	assign emit_now  = step && (len != '0);
	assign digit_end = step && ((len == '0) || k_last);

	// Sequence digits and symbols
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				valid_q <= 1'b1;
			end else if (sym.ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= (bcd != '0);
			end else if (digit_end && rest_zero) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Digit shift register, position and symbol index
	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= bcd;
			pos_q <= POS_W'(DIGITS - 1);
			k_q   <= '0;
		end else if (digit_end) begin
			dig_q <= rest;
			pos_q <= pos_q - 1'b1;
			k_q   <= '0;
		end else if (step) begin
			k_q <= k_q + 1'b1;
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (emit_now) begin
			code_q <= cur.code;
			bar_q  <= cur.bar;
			last_q <= k_last && rest_zero;
		end
	end

	assign busy         = busy_q;
	assign sym.valid    = valid_q;
	assign sym.symbol   = code_q;
	assign sym.overline = bar_q;
	assign sym.last     = last_q;

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q)
		else $error("sequencer loaded while busy");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (len != '0)) |-> (LEN_W'(k_q) < len))
		else $error("symbol index past digit pattern");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_now && k_last && rest_zero) |=> !busy_q)
		else $error("sequencer busy after final symbol");
`endif

endmodule

// File: verif/tb_roman_numeral_encoder.sv
// Testbench for roman_numeral_encoder: feeds numbers with random gaps, stalls the
// symbol port at random and checks every symbol word against an in-bench speller.
// Depends on rne_pkg, rne_ifs and the encoder RTL.
module tb_roman_numeral_encoder;
	timeunit 1ns;
	timeprecision 1ps;
	import rne_pkg::*;

	localparam int TB_DIGITS    = 6;
	localparam int POSITIONS    = (TB_DIGITS < 1) ? 1 :
		((TB_DIGITS > MAX_POS) ? MAX_POS : TB_DIGITS);
	localparam int MAX_GAP      = 12;
	localparam int RANDOM_WORDS = 450;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;

	// One symbol word as the sym port carries it
	typedef struct {
		logic [SYM_W-1:0] symbol;
		logic             overline;
		logic             last;
	} glyph_t;

	logic clk = 1'b0;
	logic arst_n;

	rne_num_if num_ch();
	rne_sym_if sym_ch();

	roman_numeral_encoder #(
		.DIGITS(TB_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.num(num_ch),
		.sym(sym_ch)
	);

	logic [NUM_W-1:0] pending_numbers[$];
	glyph_t           numeral_glyphs[$];
	int               mismatches   = 0;
	int               numbers_fed  = 0;
	int               glyphs_seen  = 0;
	int               num_wait     = 0;
	int               sym_wait     = 0;
	int               cycle_count  = 0;
	logic             num_hs       = 1'b0;
	logic             sym_hs       = 1'b0;

	always #10 clk = ~clk;

	// Symbol for one kind at a decimal position, units first
	function automatic glyph_t glyph_of(input int p, input kind_t k);
		glyph_t g;
		g.last     = 1'b0;
		g.overline = (k == KIND_ONE) ? (p >= 4) : (p >= 3);
		case (p)
			0:       g.symbol = (k == KIND_ONE) ? SYM_I : ((k == KIND_FIVE) ? SYM_V : SYM_X);
			1, 4:    g.symbol = (k == KIND_ONE) ? SYM_X : ((k == KIND_FIVE) ? SYM_L : SYM_C);
			3:       g.symbol = (k == KIND_ONE) ? SYM_M : ((k == KIND_FIVE) ? SYM_V : SYM_X);
			default: g.symbol = (k == KIND_ONE) ? SYM_C : ((k == KIND_FIVE) ? SYM_D : SYM_M);
		endcase
		return g;
	endfunction

	// Spell a number and queue its symbol words, saturating at the top value
	function automatic void spell_numeral(input logic [NUM_W-1:0] raw);
		int unsigned n;
		int unsigned cap;
		int unsigned dig[MAX_POS];
		int          p;
		int          d;
		glyph_t      word[$];
		cap = 1;
		for (p = 0; p < POSITIONS; p++)
			cap = cap * 10;
		cap = cap - 1;
		n = raw;
		if (n > cap)
			n = cap;
		for (p = 0; p < MAX_POS; p++) begin
			dig[p] = n % 10;
			n = n / 10;
		end
		for (p = POSITIONS - 1; p >= 0; p--) begin
			d = dig[p];
			if (d == 9) begin
				word.push_back(glyph_of(p, KIND_ONE));
				word.push_back(glyph_of(p, KIND_TEN));
			end else if (d == 4) begin
				word.push_back(glyph_of(p, KIND_ONE));
				word.push_back(glyph_of(p, KIND_FIVE));
			end else begin
				// five first, then the ones left over
				if (d >= 5)
					word.push_back(glyph_of(p, KIND_FIVE));
				repeat (d % 5) word.push_back(glyph_of(p, KIND_ONE));
			end
		end
		if (word.size() > 0)
			word[word.size() - 1].last = 1'b1;
		foreach (word[i])
			numeral_glyphs.push_back(word[i]);
	endfunction

	// Wait length for one word; none at all during calm stretches
	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Build a number digit by digit, with plenty of zero digits
	function automatic logic [NUM_W-1:0] digit_mix();
		int unsigned n;
		int          p;
		n = 0;
		for (p = 0; p < MAX_POS; p++)
			n = n * 10 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
		return NUM_W'(n);
	endfunction

	// Drive number words at the falling edge; hold a word until it is taken
	always @(negedge clk) begin
		if (arst_n && (!num_ch.valid || num_hs)) begin
			if (num_wait > 0) begin
				num_ch.valid <= 1'b0;
				num_wait     <= num_wait - 1;
			end else if (pending_numbers.size() > 0) begin
				num_ch.valid <= 1'b1;
				num_ch.value <= pending_numbers.pop_front();
				num_wait     <= draw_gap((numbers_fed / 30) % 3 == 2);
				numbers_fed  <= numbers_fed + 1;
			end else begin
				num_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the symbol port: draw a fresh wait after every word taken
	always @(negedge clk) begin
		int w;
		if (arst_n) begin
			w = sym_hs ? draw_gap((glyphs_seen / 50) % 3 == 1) : sym_wait;
			if (w > 0) begin
				sym_ch.ready <= 1'b0;
				sym_wait     <= w - 1;
			end else begin
				sym_ch.ready <= 1'b1;
				sym_wait     <= 0;
			end
		end
	end

	// Sample both ports at the rising edge: check symbols, spell accepted numbers
	always @(posedge clk) begin
		glyph_t want;
		num_hs <= arst_n && num_ch.valid && num_ch.ready;
		sym_hs <= arst_n && sym_ch.valid && sym_ch.ready;
		if (arst_n) begin
			if (sym_ch.valid && sym_ch.ready) begin
				glyphs_seen = glyphs_seen + 1;
				if (numeral_glyphs.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t: unexpected symbol word: got sym=%0d bar=%0b last=%0b",
						$time, sym_ch.symbol, sym_ch.overline, sym_ch.last);
				end else begin
					want = numeral_glyphs.pop_front();
					if (want.symbol !== sym_ch.symbol || want.overline !== sym_ch.overline ||
						want.last !== sym_ch.last) begin
						mismatches = mismatches + 1;
						$display("%0t: symbol word: exp sym=%0d bar=%0b last=%0b, %s",
							$time, want.symbol, want.overline, want.last,
							$sformatf("got sym=%0d bar=%0b last=%0b",
								sym_ch.symbol, sym_ch.overline, sym_ch.last));
					end
				end
			end
			if (num_ch.valid && num_ch.ready)
				spell_numeral(num_ch.value);
		end
	end

	// Fill the number queue, run reset, drain and report
	initial begin
		logic [NUM_W-1:0] v;
		int               i;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		sym_ch.ready = 1'b0;
		arst_n       = 1'b0;

		// every digit in the units, then zero digits, saturation and the longest numeral
		for (i = 0; i <= 9; i++)
			pending_numbers.push_back(NUM_W'(i));
		pending_numbers.push_back(NUM_W'(40));
		pending_numbers.push_back(NUM_W'(90));
		pending_numbers.push_back(NUM_W'(400));
		pending_numbers.push_back(NUM_W'(900));
		pending_numbers.push_back(NUM_W'(1000));
		pending_numbers.push_back(NUM_W'(4000));
		pending_numbers.push_back(NUM_W'(5000));
		pending_numbers.push_back(NUM_W'(9000));
		pending_numbers.push_back(NUM_W'(100001));
		pending_numbers.push_back(NUM_W'(444444));
		pending_numbers.push_back(NUM_W'(888888));
		pending_numbers.push_back(NUM_W'(999999));
		pending_numbers.push_back(NUM_W'(1000000));
		pending_numbers.push_back({NUM_W{1'b1}});
		pending_numbers.push_back(NUM_W'(0));

		for (i = 0; i < RANDOM_WORDS; i++) begin
			case ($urandom_range(0, 7))
				0, 1:    v = NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
				2:       v = NUM_W'($urandom_range(0, 3999));
				3:       v = NUM_W'($urandom_range(1000000, (1 << NUM_W) - 1));
				default: v = digit_mix();
			endcase
			pending_numbers.push_back(v);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() > 0 || num_ch.valid)
			@(posedge clk);
		while (numeral_glyphs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (numeral_glyphs.size() != 0) begin
			mismatches = mismatches + 1;
			$display("%0t: %0d symbol words never arrived", $time, numeral_glyphs.size());
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// End a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("%0t: cycle limit reached with %0d symbol words outstanding",
			$time, numeral_glyphs.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
